// ===== hdl/lcls_pkg.sv =====
// Shared types, constants and helpers for the LED cube layer scan serializer.
package lcls_pkg;

  localparam int MAX_LAYERS     = 8;
  localparam int WORD_BITS      = 16;
  localparam int MAX_WPL        = 4;
  localparam int STORE_DEPTH    = 32;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int SIZE_W         = 4;
  localparam int HOLD_W         = 16;
  localparam int LAYER_W        = 3;
  localparam int WCNT_W         = 3;
  localparam int BCNT_W         = $clog2(WORD_BITS);
  localparam int OP_W           = 2;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 8;

  // Layer select: bit (7 - layer) set
  localparam logic [7:0] LAYER_SEL_TOP = 8'h80;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_BLANK = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUBE_SIZE = 1'b0,
    REG_HOLD      = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHIFT = 2'd1,
    PH_LATCH = 2'd2,
    PH_HOLD  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FETCH = 2'd1,
    ST_EXEC  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic capture;  // register the accepted item
    logic fetch;    // store access for the held item
    logic exec;     // apply item, load result register
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_status_t;

  // Clamp cube size to 1..MAX_LAYERS
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    if (s > SIZE_W'(MAX_LAYERS)) r = SIZE_W'(MAX_LAYERS);
    return r;
  endfunction

  // ceil(size*size/16), limited to 1..MAX_WPL
  function automatic logic [WCNT_W-1:0] words_per_layer(input logic [SIZE_W-1:0] s);
    logic [WCNT_W-1:0] w;
    case (s)
      4'd5:    w = 3'd2;
      4'd6:    w = 3'd3;
      4'd7:    w = 3'd4;
      4'd8:    w = 3'd4;
      default: w = 3'd1;
    endcase
    if (w > WCNT_W'(MAX_WPL)) w = WCNT_W'(MAX_WPL);
    return w;
  endfunction

endpackage

// ===== hdl/lcls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lcls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/lcls_ctrl.sv =====
// Item sequencing controller: accept, store access, execute and result handoff.
module lcls_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 out_tready,
  input  lcls_pkg::dp_status_t status,
  output lcls_pkg::dp_cmd_t    cmd
);

  lcls_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcls_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.fetch   = 1'b0;
    cmd.exec    = 1'b0;
    case (state_r)
      lcls_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = lcls_pkg::ST_FETCH;
        end
      end
      lcls_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = lcls_pkg::ST_EXEC;
      end
      lcls_pkg::ST_EXEC: begin
        // wait for a free result slot
        if (!status.out_full || out_tready) begin
          cmd.exec  = 1'b1;
          state_nxt = lcls_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcls_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/lcls_dp.sv =====
// Datapath: config registers, scan counters, store addressing and result register.
module lcls_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lcls_pkg::dp_cmd_t                  cmd,
  output lcls_pkg::dp_status_t               status,
  input  logic [lcls_pkg::OP_W-1:0]          in_op,
  input  logic [lcls_pkg::ADDR_W-1:0]        in_index,
  input  logic [lcls_pkg::WORD_BITS-1:0]     in_value,
  input  logic                               cfg_we,
  input  logic [lcls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lcls_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                               ram_we,
  output logic [lcls_pkg::ADDR_W-1:0]        ram_waddr,
  output logic [lcls_pkg::WORD_BITS-1:0]     ram_wdata,
  output logic [lcls_pkg::ADDR_W-1:0]        ram_raddr,
  input  logic [lcls_pkg::WORD_BITS-1:0]     ram_rdata,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [lcls_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // held item
  lcls_pkg::op_t                    op_r;
  logic [lcls_pkg::ADDR_W-1:0]      index_r;
  logic [lcls_pkg::WORD_BITS-1:0]   value_r;

  logic [lcls_pkg::SIZE_W-1:0]      cube_size_r;
  logic [lcls_pkg::HOLD_W-1:0]      hold_ticks_r;

  lcls_pkg::phase_t                 phase_r, phase_nxt;
  logic                             blank_r, blank_nxt;
  logic [lcls_pkg::LAYER_W-1:0]     layer_r, layer_nxt;
  logic [lcls_pkg::WCNT_W-1:0]      word_r, word_nxt;
  logic [lcls_pkg::BCNT_W-1:0]      bit_r, bit_nxt;
  logic [lcls_pkg::HOLD_W-1:0]      hold_r, hold_nxt, hold_dec;

  logic                             out_valid_r;
  logic [3:0]                       res_r, res_nxt;

  logic [lcls_pkg::SIZE_W-1:0]      size_eff;
  logic [lcls_pkg::WCNT_W-1:0]      wpl;
  logic [5:0]                       addr_full;
  logic [lcls_pkg::WORD_BITS-1:0]   cur_word;
  logic                             last_layer;
  logic                             sd, sp, lp, busy;

  assign size_eff = lcls_pkg::eff_size(cube_size_r);
  assign wpl      = lcls_pkg::words_per_layer(size_eff);

  // layer * words_per_layer + (word - 1)
  assign addr_full = 6'(layer_r) * 6'(wpl) + 6'(word_r) - 6'd1;
  assign ram_raddr = addr_full[lcls_pkg::ADDR_W-1:0];
  assign ram_we    = cmd.fetch && (op_r == lcls_pkg::OP_LOAD);
  assign ram_waddr = index_r;
  assign ram_wdata = value_r;

  always_comb begin
    if (blank_r) begin
      cur_word = '0;
    end else if (word_r == '0) begin
      cur_word = lcls_pkg::WORD_BITS'(lcls_pkg::LAYER_SEL_TOP >> layer_r);
    end else begin
      cur_word = ram_rdata;
    end
  end

  assign last_layer = blank_r || ({1'b0, layer_r} + 4'd1 >= size_eff);
  assign hold_dec   = (hold_r != '0) ? hold_r - 1'b1 : hold_r;

  always_comb begin
    phase_nxt = phase_r;
    blank_nxt = blank_r;
    layer_nxt = layer_r;
    word_nxt  = word_r;
    bit_nxt   = bit_r;
    hold_nxt  = hold_r;
    sd        = 1'b0;
    sp        = 1'b0;
    lp        = 1'b0;
    busy      = (phase_r != lcls_pkg::PH_IDLE);
    case (op_r)
      lcls_pkg::OP_START, lcls_pkg::OP_BLANK: begin
        busy = 1'b1;
        if (phase_r == lcls_pkg::PH_IDLE) begin
          phase_nxt = lcls_pkg::PH_SHIFT;
          blank_nxt = (op_r == lcls_pkg::OP_BLANK);
          layer_nxt = '0;
          word_nxt  = '0;
          bit_nxt   = '0;
          hold_nxt  = '0;
        end
      end
      lcls_pkg::OP_TICK: begin
        case (phase_r)
          lcls_pkg::PH_SHIFT: begin
            sd      = cur_word[bit_r];
            sp      = 1'b1;
            bit_nxt = bit_r + 1'b1;
            if (bit_r == lcls_pkg::BCNT_W'(lcls_pkg::WORD_BITS - 1)) begin
              bit_nxt  = '0;
              word_nxt = word_r + 1'b1;
              if (word_r >= wpl) begin
                word_nxt  = '0;
                phase_nxt = lcls_pkg::PH_LATCH;
              end
            end
          end
          lcls_pkg::PH_LATCH: begin
            lp = 1'b1;
            if (!(blank_r || hold_ticks_r == '0)) begin
              hold_nxt  = hold_ticks_r;
              phase_nxt = lcls_pkg::PH_HOLD;
            end
          end
          lcls_pkg::PH_HOLD: begin
            hold_nxt = hold_dec;
          end
          default: ;
        endcase
        // layer boundary after latch (no hold) or at end of hold
        if ((phase_r == lcls_pkg::PH_LATCH && (blank_r || hold_ticks_r == '0)) ||
            (phase_r == lcls_pkg::PH_HOLD && hold_dec == '0)) begin
          if (last_layer) begin
            phase_nxt = lcls_pkg::PH_IDLE;
            blank_nxt = 1'b0;
            layer_nxt = '0;
          end else begin
            layer_nxt = layer_r + 1'b1;
            phase_nxt = lcls_pkg::PH_SHIFT;
          end
          word_nxt = '0;
          bit_nxt  = '0;
          hold_nxt = '0;
        end
      end
      default: ;
    endcase
    res_nxt = {busy, lp, sp, sd};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= lcls_pkg::op_t'(in_op);
      index_r <= in_index;
      value_r <= in_value;
    end
    if (cmd.exec) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cube_size_r  <= lcls_pkg::SIZE_W'(4);
      hold_ticks_r <= lcls_pkg::HOLD_W'(5);
      phase_r      <= lcls_pkg::PH_IDLE;
      blank_r      <= 1'b0;
      layer_r      <= '0;
      word_r       <= '0;
      bit_r        <= '0;
      hold_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (lcls_pkg::cfg_reg_t'(cfg_index))
          lcls_pkg::REG_CUBE_SIZE: cube_size_r  <= cfg_wdata[lcls_pkg::SIZE_W-1:0];
          lcls_pkg::REG_HOLD:      hold_ticks_r <= cfg_wdata[lcls_pkg::HOLD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        phase_r <= phase_nxt;
        blank_r <= blank_nxt;
        layer_r <= layer_nxt;
        word_r  <= word_nxt;
        bit_r   <= bit_nxt;
        hold_r  <= hold_nxt;
      end
      if (cmd.exec) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_full = out_valid_r;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = {{(lcls_pkg::OUT_DATA_W-4){1'b0}}, res_r};

endmodule

// ===== hdl/led_cube_layer_scan_serializer_top.sv =====
// Top level of the LED cube layer scan serializer.
// Each input item (load word, start scan, blank, tick) yields exactly one result item
// with the pin levels for the chained shift registers. From acceptance an item is first
// captured, then passes the frame store's registered read port, then updates the scan
// counters and loads the result register once a result slot is free; the next item is
// accepted in the cycle after that, while the result may still be waiting on out_tready.
// The frame store holds 32 words and has no reset; only written entries should be scanned.
// Configuration writes are meant for idle periods only.
module led_cube_layer_scan_serializer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [4:0] word_index, [20:5] word_value, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] serial_data, [1] shift_pulse, [2] latch_pulse,
                                  // [3] busy_res, rest zero
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  lcls_pkg::dp_cmd_t                 cmd;
  lcls_pkg::dp_status_t              status;
  logic                              ram_we;
  logic [lcls_pkg::ADDR_W-1:0]       ram_waddr;
  logic [lcls_pkg::ADDR_W-1:0]       ram_raddr;
  logic [lcls_pkg::WORD_BITS-1:0]    ram_wdata;
  logic [lcls_pkg::WORD_BITS-1:0]    ram_rdata;

  lcls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lcls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_op      (in_tuser),
    .in_index   (in_tdata[4:0]),
    .in_value   (in_tdata[20:5]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  lcls_ram #(
    .WIDTH (lcls_pkg::WORD_BITS),
    .DEPTH (lcls_pkg::STORE_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ===== sim/led_cube_layer_scan_serializer_top_test.sv =====
// Self-checking testbench for the LED cube layer scan serializer.
`timescale 1ns / 100ps

module led_cube_layer_scan_serializer_top_test;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE      = 6;

  // Pin levels of one result, bit 3 first as on out_tdata
  typedef struct packed {
    logic busy;
    logic latch;
    logic shift;
    logic sdata;
  } pins_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // [4:0] word_index, [20:5] word_value, rest zero
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] serial_data, [1] shift_pulse, [2] latch_pulse, [3] busy_res
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_wdata;

  led_cube_layer_scan_serializer_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Scan state mirror
  logic [15:0]      frame_mem [lcls_pkg::STORE_DEPTH];
  logic [3:0]       size_reg   = 4'd4;
  logic [15:0]      hold_reg   = 16'd5;
  lcls_pkg::phase_t scan_phase = lcls_pkg::PH_IDLE;
  logic             blank_run  = 1'b0;
  logic [2:0]       layer_cnt  = 3'd0;
  logic [2:0]       word_cnt   = 3'd0;
  logic [3:0]       bit_cnt    = 4'd0;
  logic [15:0]      hold_left  = 16'd0;

  pins_t pins_due [$];
  int    items_sent   = 0;
  int    results_seen = 0;
  int    error_count  = 0;
  int    cycle_count  = 0;
  bit    idle_on      = 1'b1;

  function automatic int cube_edge();
    int s;
    s = size_reg;
    if (s < 1) s = 1;
    if (s > lcls_pkg::MAX_LAYERS) s = lcls_pkg::MAX_LAYERS;
    return s;
  endfunction

  function automatic int layer_words();
    int w;
    w = (cube_edge() * cube_edge() + 15) / 16;
    if (w > lcls_pkg::MAX_WPL) w = lcls_pkg::MAX_WPL;
    if (w < 1) w = 1;
    return w;
  endfunction

  // Word 0 of a layer is the layer select, then the LED words
  function automatic logic [15:0] shifting_word();
    logic [4:0] addr;
    if (blank_run) return 16'h0000;
    if (word_cnt == 3'd0) return 16'(lcls_pkg::LAYER_SEL_TOP >> layer_cnt);
    addr = 5'(int'(layer_cnt) * layer_words() + int'(word_cnt) - 1);
    return frame_mem[addr];
  endfunction

  function automatic void close_layer();
    if (blank_run || int'(layer_cnt) + 1 >= cube_edge()) begin
      scan_phase = lcls_pkg::PH_IDLE;
      blank_run  = 1'b0;
      layer_cnt  = 3'd0;
    end else begin
      layer_cnt  = layer_cnt + 3'd1;
      scan_phase = lcls_pkg::PH_SHIFT;
    end
    word_cnt  = 3'd0;
    bit_cnt   = 4'd0;
    hold_left = 16'd0;
  endfunction

  function automatic pins_t predict_pins(lcls_pkg::op_t op, logic [4:0] idx,
                                         logic [15:0] val);
    pins_t       p;
    logic [15:0] w;
    p = '0;
    case (op)
      lcls_pkg::OP_LOAD: begin
        frame_mem[idx] = val;
        p.busy = (scan_phase != lcls_pkg::PH_IDLE);
      end
      lcls_pkg::OP_START, lcls_pkg::OP_BLANK: begin
        if (scan_phase == lcls_pkg::PH_IDLE) begin
          scan_phase = lcls_pkg::PH_SHIFT;
          blank_run  = (op == lcls_pkg::OP_BLANK);
          layer_cnt  = 3'd0;
          word_cnt   = 3'd0;
          bit_cnt    = 4'd0;
          hold_left  = 16'd0;
        end
        p.busy = 1'b1;
      end
      default: begin
        p.busy = (scan_phase != lcls_pkg::PH_IDLE);
        case (scan_phase)
          lcls_pkg::PH_SHIFT: begin
            w = shifting_word();
            p.sdata = w[bit_cnt];
            p.shift = 1'b1;
            if (bit_cnt == 4'd15) begin
              bit_cnt  = 4'd0;
              word_cnt = word_cnt + 3'd1;
              if (int'(word_cnt) > layer_words()) begin
                word_cnt   = 3'd0;
                scan_phase = lcls_pkg::PH_LATCH;
              end
            end else begin
              bit_cnt = bit_cnt + 4'd1;
            end
          end
          lcls_pkg::PH_LATCH: begin
            p.latch = 1'b1;
            if (blank_run || hold_reg == 16'd0) begin
              close_layer();
            end else begin
              hold_left  = hold_reg;
              scan_phase = lcls_pkg::PH_HOLD;
            end
          end
          lcls_pkg::PH_HOLD: begin
            if (hold_left != 16'd0) hold_left = hold_left - 16'd1;
            if (hold_left == 16'd0) close_layer();
          end
          default: ;
        endcase
      end
    endcase
    return p;
  endfunction

  function automatic int pick_gap();
    if (!idle_on || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  task automatic send_item(input lcls_pkg::op_t op, input logic [4:0] idx,
                           input logic [15:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, val, idx};
    do @(posedge clk); while (!in_tready);
    pins_due.push_back(predict_pins(op, idx, val));
    items_sent++;
  endtask

  task automatic settle_outputs();
    in_tvalid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input lcls_pkg::cfg_reg_t sel, input logic [15:0] value);
    settle_outputs();
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (sel == lcls_pkg::REG_CUBE_SIZE) size_reg = value[3:0];
    else hold_reg = value;
  endtask

  // Ticks (with occasional other items when noisy) until the current sequence ends, then one idle tick
  task automatic run_scan_out(input bit noisy);
    lcls_pkg::op_t op;
    while (scan_phase != lcls_pkg::PH_IDLE) begin
      op = lcls_pkg::OP_TICK;
      if (noisy && $urandom_range(0, 7) == 0)
        op = lcls_pkg::op_t'(2'($urandom_range(0, 2)));
      send_item(op, 5'($urandom), 16'($urandom));
    end
    send_item(lcls_pkg::OP_TICK, 5'($urandom), 16'($urandom));
  endtask

  task automatic test_directed_pins();
    send_item(lcls_pkg::OP_TICK, 5'h1F, 16'hFFFF);
    send_item(lcls_pkg::OP_LOAD, 5'd0, 16'hFFFF);
    send_item(lcls_pkg::OP_LOAD, 5'd1, 16'h0000);
    send_item(lcls_pkg::OP_LOAD, 5'd2, 16'hA5A5);
    send_item(lcls_pkg::OP_LOAD, 5'd3, 16'h5A5A);
    send_item(lcls_pkg::OP_START, 5'd0, 16'h0000);
    while (layer_cnt == 3'd0) send_item(lcls_pkg::OP_TICK, 5'($urandom), 16'($urandom));
    // store is read live: layer 3 shifts this word
    send_item(lcls_pkg::OP_LOAD, 5'd3, 16'h8001);
    send_item(lcls_pkg::OP_START, 5'd0, 16'h0000);
    send_item(lcls_pkg::OP_BLANK, 5'd0, 16'h0000);
    run_scan_out(1'b0);
    send_item(lcls_pkg::OP_LOAD, 5'd31, 16'hFFFF);
  endtask

  // Blanks at sizes with two and four LED words per layer, the latter above range
  task automatic test_size_sweep();
    int sweep_size [2] = '{15, 5};
    int sweep_hold [2] = '{3, 1};
    for (int i = 0; i < lcls_pkg::STORE_DEPTH; i++)
      send_item(lcls_pkg::OP_LOAD, 5'(i),
                (i == 0) ? 16'hFFFF : (i == 31) ? 16'h0000 : 16'($urandom));
    for (int i = 0; i < 2; i++) begin
      idle_on = i[0];
      write_reg(lcls_pkg::REG_CUBE_SIZE, 16'(sweep_size[i]));
      write_reg(lcls_pkg::REG_HOLD, 16'(sweep_hold[i]));
      send_item(lcls_pkg::OP_BLANK, 5'($urandom), 16'($urandom));
      run_scan_out(1'b0);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_midscan_resize();
    write_reg(lcls_pkg::REG_CUBE_SIZE, 16'd6);
    write_reg(lcls_pkg::REG_HOLD, 16'd2);
    send_item(lcls_pkg::OP_START, 5'd0, 16'h0000);
    while (layer_cnt == 3'd0 || word_cnt < 3'd2)
      send_item(lcls_pkg::OP_TICK, 5'($urandom), 16'($urandom));
    // drops to one word per layer while past it: latch comes at the next word end
    write_reg(lcls_pkg::REG_CUBE_SIZE, 16'd2);
    run_scan_out(1'b0);
  endtask

  task automatic test_random_traffic();
    int         stop_at;
    logic [3:0] sz;
    stop_at = items_sent + 40;
    while (items_sent < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        sz = ($urandom_range(0, 4) == 0) ? 4'd0 : 4'($urandom_range(1, 3));
        write_reg(lcls_pkg::REG_CUBE_SIZE, 16'(sz));
        write_reg(lcls_pkg::REG_HOLD, ($urandom_range(0, 7) == 0) ? 16'($urandom_range(7, 20))
                                                                 : 16'($urandom_range(0, 6)));
      end
      repeat ($urandom_range(0, 5))
        send_item(lcls_pkg::op_t'(2'($urandom_range(0, 3))), 5'($urandom), 16'($urandom));
      send_item(($urandom_range(0, 3) == 0) ? lcls_pkg::OP_BLANK : lcls_pkg::OP_START,
                5'($urandom), 16'($urandom));
      run_scan_out(1'b1);
      if ($urandom_range(0, 3) == 0) settle_outputs();
    end
    idle_on = 1'b1;
  endtask

  // Longer hold on a single-layer cube, no idling to keep the run short
  task automatic test_long_hold();
    idle_on = 1'b0;
    write_reg(lcls_pkg::REG_CUBE_SIZE, 16'd0);
    write_reg(lcls_pkg::REG_HOLD, 16'd24);
    send_item(lcls_pkg::OP_START, 5'($urandom), 16'($urandom));
    run_scan_out(1'b0);
    idle_on = 1'b1;
  endtask

  // Result checker
  always @(posedge clk) begin
    pins_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pins_due.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result %0d: tdata=%02h", results_seen, out_tdata);
      end else begin
        want = pins_due.pop_front();
        if (out_tdata !== {4'b0000, want}) begin
          error_count++;
          if (error_count <= 10)
            $display("result %0d: expected sd=%0b sh=%0b la=%0b busy=%0b, got %02h",
                     results_seen, want.sdata, want.shift, want.latch, want.busy, out_tdata);
        end
      end
    end
  end

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= lcls_pkg::OP_LOAD;
    cfg_we    <= 1'b0;
    cfg_index <= lcls_pkg::REG_CUBE_SIZE;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_pins();
    test_size_sweep();
    test_midscan_resize();
    test_random_traffic();
    test_long_hold();
    settle_outputs();
    $display("%0d items sent (loads, scans, blanks, ticks), %0d pin results checked",
             items_sent, results_seen);
    $display("cube sizes 0..15, holds up to 24, live store writes and resizes mid-scan");
    if (error_count == 0 && pins_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results missing", error_count, pins_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lcls_pkg.sv
hdl/lcls_ram.sv
hdl/lcls_ctrl.sv
hdl/lcls_dp.sv
hdl/led_cube_layer_scan_serializer_top.sv
sim/led_cube_layer_scan_serializer_top_test.sv
